### src/tsdr_pkg.sv
// Package for the sample-to-double record block.
// Holds record constants, type codes and the conversion input record type.
`default_nettype none
package tsdr_pkg;

    localparam int RecBytes = 14;
    localparam int CntW     = 4;

    localparam logic [3:0] TYPE_U8  = 4'd0;
    localparam logic [3:0] TYPE_U16 = 4'd1;
    localparam logic [3:0] TYPE_U32 = 4'd2;
    localparam logic [3:0] TYPE_U64 = 4'd3;
    localparam logic [3:0] TYPE_S8  = 4'd4;
    localparam logic [3:0] TYPE_S16 = 4'd5;
    localparam logic [3:0] TYPE_S32 = 4'd6;
    localparam logic [3:0] TYPE_S64 = 4'd7;
    localparam logic [3:0] TYPE_F32 = 4'd8;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
        logic        is_flt;
        logic        is_zero;
    } conv_in_t;

endpackage
`default_nettype wire

### src/tsdr_conv.sv
// Binary64 conversion stage: registered selected operand to double bits.
// Depends on tsdr_pkg; two register stages (normalise, then round/pack).
`default_nettype none
module tsdr_conv
    import tsdr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_vld,
    input  wire conv_in_t    op,
    output logic             out_vld,
    output logic [63:0]      dbl
);

    logic        vld_reg;
    logic        neg_reg;
    logic        flt_reg;
    logic        zero_reg;
    logic [5:0]  pos_reg;
    logic [63:0] norm_reg;
    logic [31:0] f_reg;
    logic [5:0]  pos_next;
    logic [63:0] norm_next;

    // leading-one position, then shift so the top bit sits at bit 63
    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (op.mag[i])
            begin
                pos_next = 6'(i);
            end
        end
        norm_next = op.mag << (6'd63 - pos_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= op.neg;
        flt_reg  <= op.is_flt;
        zero_reg <= op.is_zero || (op.mag == 64'd0);
        pos_reg  <= pos_next;
        norm_reg <= norm_next;
        f_reg    <= op.mag[31:0];
    end

    logic [52:0] m_trunc;
    logic [10:0] g_bits;
    logic        rnd_up;
    logic [63:0] int_bits;
    logic [63:0] flt_bits;
    logic [7:0]  fe;
    logic [22:0] fm;
    logic [4:0]  fp;
    logic [63:0] dbl_next;

    always_comb
    begin
        m_trunc  = norm_reg[63:11];
        g_bits   = norm_reg[10:0];
        rnd_up   = g_bits[10] && ((g_bits[9:0] != 10'd0) || m_trunc[0]);
        int_bits = {neg_reg, 63'd0}
                 + ({42'd0, 11'(11'd1022 + {5'd0, pos_reg})} << 52)
                 + {11'd0, m_trunc} + {63'd0, rnd_up};
        fe = f_reg[30:23];
        fm = f_reg[22:0];
        fp = '0;
        for (int i = 0; i < 23; i++)
        begin
            if (fm[i])
            begin
                fp = 5'(i);
            end
        end
        if (fe == 8'hFF)
        begin
            flt_bits = {f_reg[31], 11'h7FF, fm, 29'd0};
            if (fm != 23'd0)
            begin
                flt_bits[51] = 1'b1;
            end
        end
        else if (fe == 8'd0)
        begin
            if (fm == 23'd0)
            begin
                flt_bits = {f_reg[31], 63'd0};
            end
            else
            begin
                flt_bits = {f_reg[31], 11'(11'd874 + {6'd0, fp}),
                            52'({29'd0, fm} << (6'd52 - {1'b0, fp}))};
            end
        end
        else
        begin
            flt_bits = {f_reg[31], 11'({3'd0, fe} + 11'd896), fm, 29'd0};
        end
        if (flt_reg)
        begin
            dbl_next = flt_bits;
        end
        else if (zero_reg)
        begin
            dbl_next = 64'd0;
        end
        else
        begin
            dbl_next = int_bits;
        end
    end

    logic        ovld_reg;
    logic [63:0] dbl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else
        begin
            ovld_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dbl_reg <= dbl_next;
    end

    assign out_vld = ovld_reg;
    assign dbl     = dbl_reg;

endmodule
`default_nettype wire

### src/typed_sample_to_double_record_top.sv
// Top level: sample in, 14-byte big-endian record out (id, timestamp, double).
// Depends on tsdr_pkg and tsdr_conv.
//
//  channel | handshake           | payload
//  sample  | start / busy        | param_id, timestamp_ms, data_type, raw_value
//  record  | out_valid (strobe)  | out_byte, last_byte
//
// The serialiser sets the rate. The first byte is strobed once the item has passed
// opv_reg, the tsdr_conv registers vld_reg and ovld_reg, and act_reg; bytes then follow
// every cycle. busy drops for the last four bytes of a record, so the next record can
// start in the cycle after the last byte. Reset clears all control; the output
// cannot stall.
`default_nettype none
module typed_sample_to_double_record_top
    import tsdr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] param_id,
    input  wire logic [31:0] timestamp_ms,
    input  wire logic [3:0]  data_type,
    input  wire logic [63:0] raw_value,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             last_byte
);

    logic     accept;
    conv_in_t op_reg;
    conv_in_t op_next;
    logic     opv_reg;
    logic [47:0] hdr_reg;
    logic [47:0] hdr_d1_reg;
    logic [47:0] hdr_d2_reg;
    logic        cv_vld;
    logic [63:0] cv_dbl;
    logic [111:0] sh_reg;
    logic [CntW-1:0] cnt_reg;
    logic        act_reg;
    logic [1:0]  pend_reg;
    logic        pend_inc;

    assign accept = start && !busy;

    always_comb
    begin
        op_next = '{neg: 1'b0, mag: 64'd0, is_flt: 1'b0, is_zero: 1'b0};
        case (data_type)
            TYPE_U8:  op_next.mag = {56'd0, raw_value[7:0]};
            TYPE_U16: op_next.mag = {48'd0, raw_value[15:0]};
            TYPE_U32: op_next.mag = {32'd0, raw_value[31:0]};
            TYPE_U64: op_next.mag = raw_value;
            TYPE_S8:
            begin
                op_next.neg = raw_value[7];
                op_next.mag = {56'd0, raw_value[7] ? 8'(-raw_value[7:0]) : raw_value[7:0]};
            end
            TYPE_S16:
            begin
                op_next.neg = raw_value[15];
                op_next.mag = {48'd0, raw_value[15] ? 16'(-raw_value[15:0])
                                                    : raw_value[15:0]};
            end
            TYPE_S32:
            begin
                op_next.neg = raw_value[31];
                op_next.mag = {32'd0, raw_value[31] ? 32'(-raw_value[31:0])
                                                    : raw_value[31:0]};
            end
            TYPE_S64:
            begin
                op_next.neg = raw_value[63];
                op_next.mag = raw_value[63] ? -raw_value : raw_value;
            end
            TYPE_F32:
            begin
                op_next.is_flt = 1'b1;
                op_next.mag    = {32'd0, raw_value[31:0]};
            end
            default:  op_next.is_zero = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_next;
            hdr_reg <= {param_id, timestamp_ms};
        end
        hdr_d1_reg <= hdr_reg;
        hdr_d2_reg <= hdr_d1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opv_reg <= 1'b0;
        end
        else
        begin
            opv_reg <= accept;
        end
    end

    tsdr_conv u_conv (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (opv_reg),
        .op      (op_reg),
        .out_vld (cv_vld),
        .dbl     (cv_dbl)
    );

    assign pend_inc = accept;

    // pend counts items in the conversion pipe; busy covers pipe and serialiser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            act_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(pend_inc) - 2'(cv_vld);
            if (cv_vld)
            begin
                act_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (act_reg)
            begin
                if (cnt_reg == CntW'(RecBytes - 1))
                begin
                    act_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cv_vld)
        begin
            sh_reg <= {hdr_d2_reg, cv_dbl};
        end
        else if (act_reg)
        begin
            sh_reg <= {sh_reg[103:0], 8'd0};
        end
    end

    // take the next item early enough that its double lands as the last byte leaves
    assign busy = (pend_reg != 2'd0) || (act_reg && cnt_reg < CntW'(RecBytes - 4));

    assign out_valid = act_reg;
    assign out_byte  = sh_reg[111:104];
    assign last_byte = act_reg && (cnt_reg == CntW'(RecBytes - 1));

`ifndef SYNTHESIS
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        last_byte |=> !out_valid || $past(cv_vld))
        else $error("byte after last");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cv_vld |-> !act_reg || last_byte)
        else $error("record overlap");
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd1)
        else $error("pipe overfill");
`endif

endmodule
`default_nettype wire
